[design/console_number_text_formatter_top_macros.svh]
`ifndef CONSOLE_NUMBER_TEXT_FORMATTER_TOP_MACROS_SVH
`define CONSOLE_NUMBER_TEXT_FORMATTER_TOP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CNTF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define CNTF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cntf_pkg.sv]
package cntf_pkg;

   localparam int NUMBER_BITS = 16;

   localparam int HEX_DIGITS = (NUMBER_BITS + 3) / 4;
   localparam int WORK_W     = HEX_DIGITS * 4;

   function automatic int dec_digit_count();
      longint lim;
      int     cnt;
      lim = (longint'(1) << NUMBER_BITS) - 1;
      cnt = 0;
      while (lim > 0) begin
         lim = lim / 10;
         cnt = cnt + 1;
      end
      return cnt;
   endfunction

   localparam int DEC_DIGITS = dec_digit_count();
   localparam int KW         = $clog2(DEC_DIGITS);

   typedef logic [NUMBER_BITS-1:0] number_type;
   typedef logic [WORK_W-1:0]      work_type;
   typedef logic [KW-1:0]          slot_type;
   typedef work_type               pow_table_type [DEC_DIGITS];

   function automatic pow_table_type pow10_table();
      pow_table_type t;
      longint        p;
      p = 1;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         t[i] = work_type'(p);
         p = p * 10;
      end
      return t;
   endfunction

   localparam pow_table_type POW10 = pow10_table();

   typedef enum logic [1:0] {
      ACT_CHAR = 2'd0,
      ACT_DEC  = 2'd1,
      ACT_HEX  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] COLOR_RESET = 8'h0F;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'd0, d};
      end else begin
         c = CH_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

[design/cntf_req_if.sv]
interface cntf_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [7:0]           char_code;
   cntf_pkg::number_type number;

   modport source (output valid, action, char_code, number, input ready);
   modport sink   (input valid, action, char_code, number, output ready);
endinterface

[design/cntf_rsp_if.sv]
interface cntf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic [7:0] color_out;
   logic       last;

   modport source (output valid, char_out, color_out, last, input ready);
   modport sink   (input valid, char_out, color_out, last, output ready);
endinterface

[design/cntf_csr_if.sv]
interface cntf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_color;

   modport source (output valid, text_color, input ready);
   modport sink   (input valid, text_color, output ready);
endinterface

[design/console_number_text_formatter_top.sv]
// Console number and character formatter.
// req_ch takes one command per transfer: put a character, print number as
// signed decimal, or print it as uppercase hex. rsp_ch gives the console
// characters one per transfer, each with the current text color, and last
// set on the final one. csr_ch writes the text color; it is always ready.
// req_ch is ready only while no command is in progress; the final character
// may still sit in the output register when the next command is taken.
// Output per command:
//   character: CR and LF give CR,LF; BS gives BS,space,BS; others as is.
//   hex: nibbles from the top down, leading zeros suppressed.
//   decimal: a minus sign if negative, then one compare-subtract unit
//   walks the powers of ten, one subtraction per cycle, printing digits
//   with leading zeros suppressed.
// A stalled receiver holds the character; the sequencer waits, but decimal
// subtraction goes on. Reset drops rsp valid, goes idle, sets color 0x0F.
module console_number_text_formatter_top (
   input  logic       clock,
   input  logic       reset,
   cntf_req_if.sink   req_ch,
   cntf_rsp_if.source rsp_ch,
   cntf_csr_if.sink   csr_ch
);
   import cntf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHAR,
      S_SIGN,
      S_DEC,
      S_HEX
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] code_ff, code_in;
   logic [1:0] idx_ff, idx_in;
   work_type   work_ff, work_in;
   logic [3:0] digit_ff, digit_in;
   slot_type   k_ff, k_in;
   logic       started_ff, started_in;
   logic [7:0] color_ff, color_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic [7:0] rsp_color_ff, rsp_color_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free;
   number_type neg_mag;
   work_type   pow;
   logic [3:0] nib;
   logic [7:0] ch;
   logic       ch_last;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign neg_mag  = ~req_ch.number + number_type'(1);
   assign pow      = POW10[k_ff];
   assign nib      = work_ff[WORK_W-1 -: 4];

   always_comb begin
      priority if (code_ff == CH_LF || code_ff == CH_CR) begin
         ch      = (idx_ff == 2'd0) ? CH_CR : CH_LF;
         ch_last = (idx_ff == 2'd1);
      end else if (code_ff == CH_BS) begin
         ch      = (idx_ff == 2'd1) ? CH_SPACE : CH_BS;
         ch_last = (idx_ff == 2'd2);
      end else begin
         ch      = code_ff;
         ch_last = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      work_in      = work_ff;
      digit_in     = digit_ff;
      k_in         = k_ff;
      started_in   = started_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_ch.valid) begin
         color_in = csr_ch.text_color;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               started_in = 1'b0;
               digit_in   = 4'd0;
               unique case (action_type'(req_ch.action))
                  ACT_CHAR: begin
                     code_in  = req_ch.char_code;
                     idx_in   = 2'd0;
                     state_in = S_CHAR;
                  end
                  ACT_DEC: begin
                     k_in = KW'(DEC_DIGITS - 1);
                     if (req_ch.number[NUMBER_BITS-1]) begin
                        work_in  = work_type'(neg_mag);
                        state_in = S_SIGN;
                     end else begin
                        work_in  = work_type'(req_ch.number);
                        state_in = S_DEC;
                     end
                  end
                  ACT_HEX: begin
                     k_in     = KW'(HEX_DIGITS - 1);
                     work_in  = work_type'(req_ch.number);
                     state_in = S_HEX;
                  end
                  ACT_NONE: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CHAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ch;
               rsp_color_in = color_ff;
               rsp_last_in  = ch_last;
               idx_in       = idx_ff + 2'd1;
               if (ch_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_MINUS;
               rsp_color_in = color_ff;
               rsp_last_in  = 1'b0;
               state_in     = S_DEC;
            end
         end
         S_DEC: begin
            if (work_ff >= pow) begin
               work_in  = work_ff - pow;
               digit_in = digit_ff + 4'd1;
            end else if (out_free) begin
               if (digit_ff != 4'd0 || started_ff || k_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = digit_char(digit_ff);
                  rsp_color_in = color_ff;
                  rsp_last_in  = (k_ff == '0);
                  started_in   = 1'b1;
               end
               digit_in = 4'd0;
               if (k_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff - slot_type'(1);
               end
            end
         end
         S_HEX: begin
            if (out_free) begin
               if (nib != 4'd0 || started_ff || k_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = digit_char(nib);
                  rsp_color_in = color_ff;
                  rsp_last_in  = (k_ff == '0);
                  started_in   = 1'b1;
               end
               work_in = work_ff << 4;
               if (k_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff - slot_type'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
      end
      code_ff      <= code_in;
      idx_ff       <= idx_in;
      work_ff      <= work_in;
      digit_ff     <= digit_in;
      k_ff         <= k_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.char_out  = rsp_char_ff;
   assign rsp_ch.color_out = rsp_color_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

[design/cntf_checker.sv]
`include "console_number_text_formatter_top_macros.svh"

module cntf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_out,
   input logic [7:0] rsp_color_out,
   input logic       rsp_last
);
   import cntf_pkg::*;

   `CNTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_color_out) && $stable(rsp_last), "rsp changed while stalled")
   `CNTF_ASSERT(a_busy_after_cmd, clock, reset, req_valid && req_ready && req_action != ACT_NONE |=> !req_ready, "ready right after a printing command")
   `CNTF_ASSERT(a_busy_mid_text, clock, reset, rsp_valid && rsp_ready && !rsp_last |=> rsp_valid || !req_ready, "ready before the final character")
   `CNTF_ASSERT(a_idle_pending_last, clock, reset, req_ready && rsp_valid |-> rsp_last, "idle while a non-final character waits")
   `CNTF_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid, "rsp valid right after reset")

endmodule

bind console_number_text_formatter_top cntf_checker u_cntf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_action    (req_ch.action),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_out  (rsp_ch.char_out),
   .rsp_color_out (rsp_ch.color_out),
   .rsp_last      (rsp_ch.last)
);
